FILE: rtl/olist_pkg.sv
package olist_pkg;

	// request codes
	localparam logic [2:0] REQ_INS_HEAD = 3'd0;
	localparam logic [2:0] REQ_INS_TAIL = 3'd1;
	localparam logic [2:0] REQ_INS_POS  = 3'd2;
	localparam logic [2:0] REQ_POP_HEAD = 3'd3;
	localparam logic [2:0] REQ_POP_TAIL = 3'd4;
	localparam logic [2:0] REQ_REMOVE   = 3'd5;
	localparam logic [2:0] REQ_SEARCH   = 3'd6;

	// status codes
	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_EMPTY    = 3'd1;
	localparam logic [2:0] ST_BADPOS   = 3'd2;
	localparam logic [2:0] ST_FULL     = 3'd3;
	localparam logic [2:0] ST_NOTFOUND = 3'd4;

	typedef struct packed {
		logic [2:0]  req_type;
		logic [31:0] item_value;
		logic [6:0]  insert_position;
	} olist_req_t;

	typedef struct packed {
		logic [31:0] removed_value;
		logic [5:0]  found_position;
		logic [2:0]  status;
		logic [6:0]  entry_count;
	} olist_rsp_t;

endpackage

FILE: rtl/olist_ram.sv
module olist_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered read port, read data held between reads
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: rtl/ordered_list_engine.sv
// Bounded ordered list of data words held as a doubly linked list in three node
// memories (data, forward link, backward link) with a free list. One request is
// accepted when start is high and busy is low; its single result appears on
// result for exactly one cycle with done high and must be taken then. Head and
// tail inserts read the free node's link and then link the new node in; pops
// read the end node, unlink it and push it onto the free list; errors go
// straight to the response state. Position insert, value removal and search
// walk the list from the head at one node per cycle through the memory read
// ports; a search or removal with no match stops after the last entry. Busy
// stays high until the cycle after done. No initialisation pass is needed
// after reset.
module ordered_list_engine #(
	parameter int CAPACITY   = 64,
	parameter int DATA_WIDTH = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  olist_pkg::olist_req_t request,
	output logic                  busy,
	output logic                  done,
	output olist_pkg::olist_rsp_t result
);

	import olist_pkg::*;

	localparam int IW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int PW = (CW > 7) ? CW : 7;
	localparam int SW = (DATA_WIDTH < 32) ? DATA_WIDTH : 32;

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_WSTART = 4'd1;
	localparam logic [3:0] S_WALK   = 4'd2;
	localparam logic [3:0] S_POPRD  = 4'd3;
	localparam logic [3:0] S_REMOVE = 4'd4;
	localparam logic [3:0] S_GIVE   = 4'd5;
	localparam logic [3:0] S_ALLOC  = 4'd6;
	localparam logic [3:0] S_LINK   = 4'd7;
	localparam logic [3:0] S_LINK2  = 4'd8;
	localparam logic [3:0] S_RESP   = 4'd9;

	localparam logic [1:0] K_HEAD = 2'd0;
	localparam logic [1:0] K_TAIL = 2'd1;
	localparam logic [1:0] K_MID  = 2'd2;

	// control state
	logic [3:0]    state_q, state_d;
	logic [IW-1:0] head_q, head_d, tail_q, tail_d, free_q, free_d;
	logic [CW-1:0] count_q, count_d, hwm_q, hwm_d;

	// per-transaction working registers
	logic [2:0]    op_q, op_d;
	logic [SW-1:0] val_q, val_d;
	logic [6:0]    pos_q, pos_d;
	logic [1:0]    kind_q, kind_d;
	logic [IW-1:0] cur_q, cur_d, nx_q, nx_d, nn_q, nn_d;
	logic [CW-1:0] i_q, i_d;
	logic [31:0]   removed_q, removed_d;
	logic [5:0]    found_q, found_d;
	logic [2:0]    status_q, status_d;

	// memory ports
	logic          d_we, n_we, p_we, d_re, n_re, p_re;
	logic [IW-1:0] d_waddr, n_waddr, p_waddr, d_raddr, n_raddr, p_raddr;
	logic [SW-1:0] d_wdata, d_rdata;
	logic [IW-1:0] n_wdata, p_wdata, n_rdata, p_rdata;

	logic          full, pristine;
	logic [IW-1:0] fresh_next;

	olist_ram #(.WIDTH(SW), .DEPTH(CAPACITY)) u_data (
		.clk(clk), .we(d_we), .waddr(d_waddr), .wdata(d_wdata),
		.re(d_re), .raddr(d_raddr), .rdata(d_rdata)
	);

	olist_ram #(.WIDTH(IW), .DEPTH(CAPACITY)) u_next (
		.clk(clk), .we(n_we), .waddr(n_waddr), .wdata(n_wdata),
		.re(n_re), .raddr(n_raddr), .rdata(n_rdata)
	);

	olist_ram #(.WIDTH(IW), .DEPTH(CAPACITY)) u_prev (
		.clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
		.re(p_re), .raddr(p_raddr), .rdata(p_rdata)
	);

	// free node never handed out yet: its link is the implicit chain
	assign full       = (count_q >= CW'(CAPACITY));
	assign pristine   = (hwm_q < CW'(CAPACITY)) && (free_q == IW'(hwm_q));
	assign fresh_next = (free_q == IW'(CAPACITY - 1)) ? '0 : free_q + IW'(1);

	// sequencer
	always_comb begin
		state_d   = state_q;
		head_d    = head_q;
		tail_d    = tail_q;
		free_d    = free_q;
		count_d   = count_q;
		hwm_d     = hwm_q;
		op_d      = op_q;
		val_d     = val_q;
		pos_d     = pos_q;
		kind_d    = kind_q;
		cur_d     = cur_q;
		nx_d      = nx_q;
		nn_d      = nn_q;
		i_d       = i_q;
		removed_d = removed_q;
		found_d   = found_q;
		status_d  = status_q;
		d_we = 1'b0; d_waddr = '0; d_wdata = '0; d_re = 1'b0; d_raddr = '0;
		n_we = 1'b0; n_waddr = '0; n_wdata = '0; n_re = 1'b0; n_raddr = '0;
		p_we = 1'b0; p_waddr = '0; p_wdata = '0; p_re = 1'b0; p_raddr = '0;

		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					op_d      = request.req_type;
					val_d     = SW'(request.item_value);
					pos_d     = request.insert_position;
					removed_d = '0;
					found_d   = '0;
					status_d  = ST_OK;
					state_d   = S_RESP;
					unique case (request.req_type)
						REQ_INS_HEAD, REQ_INS_TAIL: begin
							if (full) begin
								status_d = ST_FULL;
							end else begin
								kind_d  = (request.req_type == REQ_INS_HEAD) ? K_HEAD : K_TAIL;
								state_d = S_ALLOC;
							end
						end
						REQ_INS_POS: begin
							if (PW'(request.insert_position) > PW'(count_q)) begin
								status_d = ST_BADPOS;
							end else if (full) begin
								status_d = ST_FULL;
							end else if (request.insert_position == 7'd0) begin
								kind_d  = K_HEAD;
								state_d = S_ALLOC;
							end else if (PW'(request.insert_position) == PW'(count_q)) begin
								kind_d  = K_TAIL;
								state_d = S_ALLOC;
							end else begin
								kind_d  = K_MID;
								state_d = S_WSTART;
							end
						end
						REQ_POP_HEAD, REQ_POP_TAIL: begin
							if (count_q == '0) begin
								status_d = ST_EMPTY;
							end else begin
								state_d = S_POPRD;
							end
						end
						REQ_REMOVE, REQ_SEARCH: begin
							if (count_q == '0) begin
								status_d = ST_NOTFOUND;
							end else begin
								state_d = S_WSTART;
							end
						end
						default: begin
							status_d = ST_OK;
						end
					endcase
				end
			end

			// first read of the walk at the head
			S_WSTART: begin
				d_re = 1'b1; n_re = 1'b1; p_re = 1'b1;
				d_raddr = head_q; n_raddr = head_q; p_raddr = head_q;
				cur_d   = head_q;
				i_d     = '0;
				state_d = S_WALK;
			end

			// read data belongs to cur_q at step i_q
			S_WALK: begin
				if (op_q == REQ_INS_POS) begin
					if (PW'(i_q) + PW'(1) == PW'(pos_q)) begin
						nx_d    = n_rdata;
						state_d = S_ALLOC;
					end else begin
						d_re = 1'b1; n_re = 1'b1; p_re = 1'b1;
						d_raddr = n_rdata; n_raddr = n_rdata; p_raddr = n_rdata;
						cur_d = n_rdata;
						i_d   = i_q + CW'(1);
					end
				end else if (d_rdata == val_q) begin
					if (op_q == REQ_SEARCH) begin
						found_d = 6'(i_q);
						state_d = S_RESP;
					end else begin
						state_d = S_REMOVE;
					end
				end else if (i_q + CW'(1) == count_q) begin
					status_d = ST_NOTFOUND;
					state_d  = S_RESP;
				end else begin
					d_re = 1'b1; n_re = 1'b1; p_re = 1'b1;
					d_raddr = n_rdata; n_raddr = n_rdata; p_raddr = n_rdata;
					cur_d = n_rdata;
					i_d   = i_q + CW'(1);
				end
			end

			S_POPRD: begin
				cur_d = (op_q == REQ_POP_HEAD) ? head_q : tail_q;
				d_re = 1'b1; n_re = 1'b1; p_re = 1'b1;
				d_raddr = cur_d; n_raddr = cur_d; p_raddr = cur_d;
				i_d     = '0;
				state_d = S_REMOVE;
			end

			// unlink cur_q from its neighbours
			S_REMOVE: begin
				if (op_q == REQ_POP_HEAD || op_q == REQ_POP_TAIL) begin
					removed_d = 32'(d_rdata);
				end
				state_d = S_GIVE;
				priority if (op_q == REQ_POP_HEAD || (op_q == REQ_REMOVE && i_q == '0)) begin
					if (count_q > CW'(1)) begin
						head_d = n_rdata;
					end
				end else if (op_q == REQ_POP_TAIL || i_q + CW'(1) == count_q) begin
					if (count_q > CW'(1)) begin
						tail_d = p_rdata;
					end
				end else begin
					n_we = 1'b1; n_waddr = p_rdata; n_wdata = n_rdata;
					p_we = 1'b1; p_waddr = n_rdata; p_wdata = p_rdata;
				end
			end

			// push the freed node onto the free list
			S_GIVE: begin
				n_we = 1'b1; n_waddr = cur_q; n_wdata = free_q;
				free_d  = cur_q;
				count_d = count_q - CW'(1);
				state_d = S_RESP;
			end

			S_ALLOC: begin
				n_re    = 1'b1;
				n_raddr = free_q;
				state_d = S_LINK;
			end

			// take the free node and link it in
			S_LINK: begin
				d_we = 1'b1; d_waddr = free_q; d_wdata = val_q;
				if (pristine) begin
					free_d = fresh_next;
					hwm_d  = hwm_q + CW'(1);
				end else begin
					free_d = n_rdata;
				end
				count_d = count_q + CW'(1);
				nn_d    = free_q;
				state_d = S_RESP;
				unique case (kind_q)
					K_HEAD: begin
						if (count_q != '0) begin
							n_we = 1'b1; n_waddr = free_q; n_wdata = head_q;
							p_we = 1'b1; p_waddr = head_q; p_wdata = free_q;
						end else begin
							tail_d = free_q;
						end
						head_d = free_q;
					end
					K_TAIL: begin
						if (count_q != '0) begin
							p_we = 1'b1; p_waddr = free_q; p_wdata = tail_q;
							n_we = 1'b1; n_waddr = tail_q; n_wdata = free_q;
						end else begin
							head_d = free_q;
						end
						tail_d = free_q;
					end
					default: begin
						n_we = 1'b1; n_waddr = free_q; n_wdata = nx_q;
						p_we = 1'b1; p_waddr = free_q; p_wdata = cur_q;
						state_d = S_LINK2;
					end
				endcase
			end

			S_LINK2: begin
				n_we = 1'b1; n_waddr = cur_q; n_wdata = nn_q;
				p_we = 1'b1; p_waddr = nx_q;  p_wdata = nn_q;
				state_d = S_RESP;
			end

			S_RESP: begin
				state_d = S_IDLE;
			end

			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			head_q  <= '0;
			tail_q  <= '0;
			free_q  <= '0;
			count_q <= '0;
			hwm_q   <= '0;
		end else begin
			state_q <= state_d;
			head_q  <= head_d;
			tail_q  <= tail_d;
			free_q  <= free_d;
			count_q <= count_d;
			hwm_q   <= hwm_d;
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		op_q      <= op_d;
		val_q     <= val_d;
		pos_q     <= pos_d;
		kind_q    <= kind_d;
		cur_q     <= cur_d;
		nx_q      <= nx_d;
		nn_q      <= nn_d;
		i_q       <= i_d;
		removed_q <= removed_d;
		found_q   <= found_d;
		status_q  <= status_d;
	end

	// result transaction
	assign busy                  = (state_q != S_IDLE);
	assign done                  = (state_q == S_RESP);
	assign result.removed_value  = removed_q;
	assign result.found_position = found_q;
	assign result.status         = status_q;
	assign result.entry_count    = 7'(count_q);

endmodule

FILE: tb/tb_ordered_list_engine.sv
module tb_ordered_list_engine;
	import olist_pkg::*;

	localparam int CAP = 64;
	localparam logic [2:0] REQ_UNUSED = 3'd7;

	logic       clk;
	logic       arst_n;
	logic       start;
	olist_req_t request;
	logic       busy;
	logic       done;
	olist_rsp_t result;

	ordered_list_engine #(.CAPACITY(CAP), .DATA_WIDTH(32)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.request(request),
		.busy(busy),
		.done(done),
		.result(result)
	);

	// list image held as an ordered array of words
	logic [31:0] list_words[$];
	olist_req_t  pending_reqs[$];
	olist_rsp_t  expected_rsps[$];
	int          fail_count = 0;
	logic        hold_off = 1'b0;
	int          gap_left = 0;
	int          burst_left = 0;

	// predict the result of one request and update the list image
	function automatic olist_rsp_t apply_request(olist_req_t r);
		olist_rsp_t o;
		int         i;
		int         hit;
		o = '0;
		o.status = ST_OK;
		hit = -1;
		case (r.req_type)
			REQ_INS_HEAD, REQ_INS_TAIL: begin
				if (list_words.size() >= CAP) o.status = ST_FULL;
				else if (r.req_type == REQ_INS_HEAD) list_words.push_front(r.item_value);
				else list_words.push_back(r.item_value);
			end
			REQ_INS_POS: begin
				if (r.insert_position > list_words.size()) o.status = ST_BADPOS;
				else if (list_words.size() >= CAP) o.status = ST_FULL;
				else list_words.insert(int'(r.insert_position), r.item_value);
			end
			REQ_POP_HEAD, REQ_POP_TAIL: begin
				if (list_words.size() == 0) o.status = ST_EMPTY;
				else if (r.req_type == REQ_POP_HEAD) o.removed_value = list_words.pop_front();
				else o.removed_value = list_words.pop_back();
			end
			REQ_REMOVE, REQ_SEARCH: begin
				for (i = 0; i < list_words.size(); i++)
					if (hit < 0 && list_words[i] == r.item_value) hit = i;
				if (hit < 0) o.status = ST_NOTFOUND;
				else if (r.req_type == REQ_SEARCH) o.found_position = hit[5:0];
				else list_words.delete(hit);
			end
			default: ;
		endcase
		o.entry_count = 7'(list_words.size());
		return o;
	endfunction

	function automatic olist_req_t make_req(logic [2:0] t, logic [31:0] v, logic [6:0] p);
		olist_req_t r;
		r.req_type = t;
		r.item_value = v;
		r.insert_position = p;
		return r;
	endfunction

	// value drawn mostly from a small pool so removals and searches hit
	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 3))
			0: return $urandom();
			1: return {$urandom_range(0, 1) ? 16'hffff : 16'h0000, 16'(0)} | $urandom_range(0, 3);
			default: return $urandom_range(0, 15);
		endcase
	endfunction

	// clock
	initial clk = 1'b0;
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// driver: bursts with random gaps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			request <= '0;
			gap_left <= 0;
			burst_left <= 0;
		end else if (start && busy) begin
			// transaction still waiting for acceptance
		end else begin
			if (start) begin
				expected_rsps.push_back(apply_request(request));
				void'(pending_reqs.pop_front());
			end
			if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				start <= 1'b0;
			end else if (pending_reqs.size() > 0 && !hold_off) begin
				request <= pending_reqs[0];
				start <= 1'b1;
				if (burst_left > 0) begin
					burst_left <= burst_left - 1;
				end else begin
					burst_left <= $urandom_range(0, 12);
					gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
				end
			end else begin
				start <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		olist_rsp_t e;
		if (arst_n && done) begin
			if (expected_rsps.size() == 0) begin
				$error("unexpected transaction result %p", result);
				fail_count++;
			end else begin
				e = expected_rsps.pop_front();
				if (result.removed_value !== e.removed_value) begin
					$error("removed_value exp %h got %h", e.removed_value, result.removed_value);
					fail_count++;
				end
				if (result.found_position !== e.found_position) begin
					$error("found_position exp %0d got %0d", e.found_position,
						result.found_position);
					fail_count++;
				end
				if (result.status !== e.status) begin
					$error("status exp %0d got %0d", e.status, result.status);
					fail_count++;
				end
				if (result.entry_count !== e.entry_count) begin
					$error("entry_count exp %0d got %0d", e.entry_count, result.entry_count);
					fail_count++;
				end
			end
		end
	end

	// stimulus
	initial begin
		int          k;
		int          n;
		int          depth;
		logic [2:0]  t;
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// directed: empty cases, extremes, unused code, duplicates
		pending_reqs.push_back(make_req(REQ_POP_HEAD, 32'h0, 7'd0));
		pending_reqs.push_back(make_req(REQ_POP_TAIL, 32'h0, 7'd0));
		pending_reqs.push_back(make_req(REQ_SEARCH, 32'h5, 7'd0));
		pending_reqs.push_back(make_req(REQ_REMOVE, 32'h5, 7'd0));
		pending_reqs.push_back(make_req(REQ_INS_POS, 32'h1, 7'd1));
		pending_reqs.push_back(make_req(REQ_INS_POS, 32'hffffffff, 7'd0));
		pending_reqs.push_back(make_req(REQ_INS_HEAD, 32'h0, 7'h7f));
		pending_reqs.push_back(make_req(REQ_INS_TAIL, 32'h5, 7'd0));
		pending_reqs.push_back(make_req(REQ_INS_POS, 32'h5, 7'd3));
		pending_reqs.push_back(make_req(REQ_INS_POS, 32'h7, 7'd2));
		pending_reqs.push_back(make_req(REQ_INS_POS, 32'h7, 7'd99));
		pending_reqs.push_back(make_req(REQ_SEARCH, 32'h5, 7'd0));
		pending_reqs.push_back(make_req(REQ_SEARCH, 32'hffffffff, 7'd0));
		pending_reqs.push_back(make_req(REQ_REMOVE, 32'h7, 7'd0));
		pending_reqs.push_back(make_req(REQ_REMOVE, 32'h5, 7'd0));
		pending_reqs.push_back(make_req(REQ_UNUSED, 32'h12345678, 7'h55));
		pending_reqs.push_back(make_req(REQ_POP_TAIL, 32'h0, 7'd0));
		pending_reqs.push_back(make_req(REQ_POP_HEAD, 32'h0, 7'd0));
		// fill to capacity and overflow through every insert kind
		for (k = 0; k < CAP; k++)
			pending_reqs.push_back(make_req(k[0] ? REQ_INS_TAIL : REQ_INS_HEAD, pick_value(),
				7'd0));
		pending_reqs.push_back(make_req(REQ_INS_HEAD, 32'h1, 7'd0));
		pending_reqs.push_back(make_req(REQ_INS_TAIL, 32'h1, 7'd0));
		pending_reqs.push_back(make_req(REQ_INS_POS, 32'h1, 7'd64));
		pending_reqs.push_back(make_req(REQ_INS_POS, 32'h1, 7'd65));
		pending_reqs.push_back(make_req(REQ_SEARCH, 32'habcdef01, 7'd0));

		// pause until every result is back
		wait (pending_reqs.size() == 0 && !start);
		hold_off = 1'b1;
		wait (expected_rsps.size() == 0);
		hold_off = 1'b0;

		// random phases, alternately growing and shrinking the list
		depth = CAP;
		for (n = 0; n < 700; n++) begin
			if ((n / 100) % 2 == 1) t = ($urandom_range(0, 9) < 6) ? 3'($urandom_range(3, 5))
				: 3'($urandom_range(0, 7));
			else t = ($urandom_range(0, 9) < 6) ? 3'($urandom_range(0, 2))
				: 3'($urandom_range(0, 7));
			pending_reqs.push_back(make_req(t, pick_value(),
				($urandom_range(0, 9) == 0) ? 7'($urandom) : 7'($urandom_range(0, depth))));
			if (pending_reqs.size() > 20) wait (pending_reqs.size() <= 10);
			depth = list_words.size() + 2;
		end
		wait (pending_reqs.size() == 0 && !start);
		wait (expected_rsps.size() == 0);
		repeat (CAP + 20) @(posedge clk);
		if (fail_count == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

	// watchdog
	initial begin
		#(12 * 400000);
		$display("status: fail");
		$finish;
	end

endmodule
